// File: rtl/ddo_pkg.sv
// ddo_pkg: constants, action codes and helper functions for the odometry block
// used by ddo_mul and diff_drive_odometry
package ddo_pkg;

  localparam int MAX_STEP_US  = 1000000;
  localparam int CORDIC_STEPS = 16;
  localparam int COR_N        = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int DT_W         = $clog2(MAX_STEP_US + 1);

  // pi/30 in Q24, 2^47/(pi*1e6), limit gain in Q30
  localparam logic [32:0] WHEEL_K     = 33'd1756906;
  localparam logic [32:0] ANG_K       = 33'd44798134;
  localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
  localparam logic [20:0] US_PER_S    = 21'd1000000;

  localparam int MUL_BITS = 33;

  localparam logic [1:0] ACT_STATUS = 2'd0;
  localparam logic [1:0] ACT_SETPOSE = 2'd1;
  localparam logic [1:0] ACT_RESET  = 2'd2;

  localparam logic [2:0] REG_WHEEL_RADIUS = 3'd0;
  localparam logic [2:0] REG_INV_TRACK    = 3'd1;
  localparam logic [2:0] REG_RPM_SCALE    = 3'd2;
  localparam logic [2:0] REG_INVERT_LEFT  = 3'd3;
  localparam logic [2:0] REG_INVERT_RIGHT = 3'd4;
  localparam logic [2:0] REG_SWAP_SIDES   = 3'd5;

  typedef logic signed [63:0] wide_t;

  function automatic logic [31:0] sat32(input wide_t v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // arctan(2^-i) as a fraction of a turn, Q32
  function automatic logic [31:0] atan_q32(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/ddo_mul.sv
// ddo_mul: bit-serial shift-add multiplier, 64-bit signed by 33-bit signed, mod 2^64
// one multiplier bit per cycle; uses ddo_pkg
module ddo_mul
  import ddo_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  wide_t       a,
  input  logic [32:0] b,
  output logic        done,
  output wide_t       p
);

  wide_t       a_r, acc_r, acc_nxt, addend;
  logic [32:0] b_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;

  // top bit of b carries negative weight
  always_comb begin
    addend = '0;
    if (b_r[0]) addend = (cnt_r == 6'(MUL_BITS - 1)) ? -a_r : a_r;
    acc_nxt = acc_r + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == 6'(MUL_BITS - 1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'(MUL_BITS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      a_r   <= a_r <<< 1;
      b_r   <= b_r >> 1;
      cnt_r <= cnt_r + 6'd1;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

// File: rtl/diff_drive_odometry.sv
// diff_drive_odometry: midpoint-heading dead reckoning from two motor rpm readings
// uses ddo_pkg and the serial multiplier ddo_mul
//
// One item at a time. Set-pose and reset items and status items that produce no step
// skip the multiplier. A full status step runs thirteen passes through the bit-serial
// multiplier, the CORDIC rotation and two bit-serial divisions by 1e6. A finished
// pose waits in the output register; the next item is taken only after the step,
// so the input stalls while a step is running.
module diff_drive_odometry
  import ddo_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [31:0]        in_timestamp_us,
  input  logic               in_has_motors,
  input  logic signed [15:0] in_rpm_motor0,
  input  logic signed [15:0] in_rpm_motor1,
  input  logic signed [31:0] in_init_x,
  input  logic signed [31:0] in_init_y,
  input  logic signed [15:0] in_init_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [15:0] out_heading,
  output logic signed [31:0] out_lin_speed,
  output logic signed [31:0] out_turn_rate,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MGO   = 3'd1;
  localparam logic [2:0] S_MWAIT = 3'd2;
  localparam logic [2:0] S_COR   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  // config
  logic [15:0] wheel_radius_r, rpm_scale_r;
  logic [23:0] inv_track_r;
  logic        inv_left_r, inv_right_r, swap_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // pose state
  logic [31:0] x_r, y_r, speed_lin_r, speed_ang_r, prev_time_r;
  logic [15:0] yaw_r, yinc_r;
  logic        time_valid_r, pose_valid_r;

  // sequencer
  logic [2:0]  state_r;
  logic [3:0]  ph_r;
  logic [DT_W-1:0] dt_r;
  logic [15:0] rpm_r_r, rpm_l_r;
  wide_t       wr_r, wl_r;

  // cordic
  logic signed [33:0] cx_r, cy_r, cdx, cdy;
  logic signed [32:0] cz_r, cat;
  logic signed [32:0] c_r, s_r;
  logic [4:0]  ci_r;
  logic        flip_r;

  // divider
  logic [63:0] dmag_r;
  logic [19:0] drem_r;
  logic [20:0] dtrial;
  logic        dneg_r, dbit;
  logic [6:0]  dcnt_r;
  logic [63:0] dquo;

  // multiplier
  logic        mul_start, mul_done;
  wide_t       mul_a, mul_p;
  logic [32:0] mul_b;

  // input decode
  logic        in_acc;
  logic [31:0] dt_full;
  logic        step_ok;

  // capture helpers
  wide_t       rnd24, vl_new, lin_sum;
  logic [63:0] yaw_rnd;
  logic [31:0] mid, mid_f;

  logic        out_valid_r, emit_go;
  logic [31:0] ox_r, oy_r, olin_r, oang_r;
  logic [15:0] oyaw_r;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign dt_full  = in_timestamp_us - prev_time_r;
  assign step_ok  = (dt_full != 32'd0) && (dt_full <= 32'(MAX_STEP_US)) && in_has_motors;
  assign emit_go  = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      REG_WHEEL_RADIUS: prdata = {16'd0, wheel_radius_r};
      REG_INV_TRACK:    prdata = {8'd0, inv_track_r};
      REG_RPM_SCALE:    prdata = {16'd0, rpm_scale_r};
      REG_INVERT_LEFT:  prdata = {31'd0, inv_left_r};
      REG_INVERT_RIGHT: prdata = {31'd0, inv_right_r};
      REG_SWAP_SIDES:   prdata = {31'd0, swap_r};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_radius_r <= 16'd5571;
      inv_track_r    <= 24'd103207;
      rpm_scale_r    <= 16'd256;
      inv_left_r     <= 1'b0;
      inv_right_r    <= 1'b0;
      swap_r         <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WHEEL_RADIUS: wheel_radius_r <= pwdata[15:0];
        REG_INV_TRACK:    inv_track_r    <= pwdata[23:0];
        REG_RPM_SCALE:    rpm_scale_r    <= pwdata[15:0];
        REG_INVERT_LEFT:  inv_left_r     <= pwdata[0];
        REG_INVERT_RIGHT: inv_right_r    <= pwdata[0];
        REG_SWAP_SIDES:   swap_r         <= pwdata[0];
        default: ;
      endcase
    end
  end

  // multiplier operands per phase
  assign mul_start = (state_r == S_MGO);
  always_comb begin
    mul_a = wr_r;
    mul_b = 33'(wheel_radius_r);
    case (ph_r)
      4'd0:  begin mul_a = 64'(signed'(rpm_r_r)); mul_b = 33'(rpm_scale_r); end
      4'd1:  begin mul_a = 64'(signed'(rpm_l_r)); mul_b = 33'(rpm_scale_r); end
      4'd2:  begin mul_a = wr_r; mul_b = 33'(wheel_radius_r); end
      4'd3:  begin mul_a = wl_r; mul_b = 33'(wheel_radius_r); end
      4'd4:  begin mul_a = wr_r; mul_b = WHEEL_K; end
      4'd5:  begin mul_a = wl_r; mul_b = WHEEL_K; end
      4'd6:  begin mul_a = wr_r; mul_b = 33'(inv_track_r); end
      4'd7:  begin mul_a = 64'(signed'(speed_ang_r)); mul_b = 33'(dt_r); end
      4'd8:  begin mul_a = wr_r; mul_b = ANG_K; end
      4'd9:  begin mul_a = 64'(signed'(speed_lin_r)); mul_b = c_r; end
      4'd10: begin mul_a = wr_r; mul_b = 33'(dt_r); end
      4'd11: begin mul_a = 64'(signed'(speed_lin_r)); mul_b = s_r; end
      4'd12: begin mul_a = wr_r; mul_b = 33'(dt_r); end
      default: ;
    endcase
  end

  ddo_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    rnd24   = (mul_p + 64'sd8388608) >>> 24;
    vl_new  = rnd24;
    lin_sum = wr_r + vl_new;
    yaw_rnd = mul_p + 64'h0000_8000_0000_0000;
    mid     = {yaw_r, 16'd0} + {mul_p[63], mul_p[63:33]};
    mid_f   = {mid[31] ^ (mid[31] ^ mid[30]), mid[30:0]};
    cdx     = cy_r >>> ci_r;
    cdy     = cx_r >>> ci_r;
    cat     = 33'(atan_q32(ci_r));
    dtrial  = {drem_r, dmag_r[63]};
    dbit    = (dtrial >= US_PER_S);
    dquo    = dneg_r ? (~dmag_r + 64'd1) : dmag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ph_r         <= '0;
      time_valid_r <= 1'b0;
      pose_valid_r <= 1'b0;
      x_r          <= '0;
      y_r          <= '0;
      yaw_r        <= '0;
      speed_lin_r  <= '0;
      speed_ang_r  <= '0;
      prev_time_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_action)
              ACT_SETPOSE: begin
                x_r          <= in_init_x;
                y_r          <= in_init_y;
                yaw_r        <= in_init_heading;
                pose_valid_r <= 1'b1;
                time_valid_r <= 1'b0;
              end
              ACT_RESET: begin
                x_r          <= '0;
                y_r          <= '0;
                yaw_r        <= '0;
                speed_lin_r  <= '0;
                speed_ang_r  <= '0;
                time_valid_r <= 1'b0;
              end
              ACT_STATUS: begin
                if (pose_valid_r) begin
                  prev_time_r <= in_timestamp_us;
                  if (!time_valid_r) begin
                    time_valid_r <= 1'b1;
                    state_r      <= S_EMIT;
                  end else if (step_ok) begin
                    ph_r    <= '0;
                    state_r <= S_MGO;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_MGO: state_r <= S_MWAIT;
        S_MWAIT: begin
          if (mul_done) begin
            ph_r <= ph_r + 4'd1;
            if (ph_r == 4'd8) state_r <= S_COR;
            else if (ph_r == 4'd10 || ph_r == 4'd12) state_r <= S_DIV;
            else state_r <= S_MGO;
            case (ph_r)
              4'd0: wr_r <= inv_right_r ? -mul_p : mul_p;
              4'd1: wl_r <= inv_left_r ? -mul_p : mul_p;
              4'd2: wr_r <= mul_p >>> 8;
              4'd3: wl_r <= mul_p >>> 8;
              4'd4: wr_r <= rnd24;
              4'd5: begin
                speed_lin_r <= sat32(lin_sum >>> 1);
                wr_r        <= wr_r - vl_new;
              end
              4'd6: speed_ang_r <= sat32(mul_p >>> 16);
              4'd7: wr_r <= mul_p;
              4'd8: begin
                yinc_r  <= yaw_rnd[63:48];
                flip_r  <= mid[31] ^ mid[30];
                cx_r    <= CORDIC_GAIN;
                cy_r    <= '0;
                cz_r    <= 33'(signed'(mid_f));
                ci_r    <= '0;
              end
              4'd9, 4'd11: wr_r <= mul_p >>> 30;
              default: begin
                // scaled distance times dt, now divide by 1e6
                dneg_r  <= mul_p[63];
                dmag_r  <= mul_p[63] ? -mul_p : mul_p;
                drem_r  <= '0;
                dcnt_r  <= '0;
              end
            endcase
          end
        end
        S_COR: begin
          if (ci_r == 5'(COR_N)) begin
            c_r     <= flip_r ? 33'(-cx_r) : cx_r[32:0];
            s_r     <= flip_r ? 33'(-cy_r) : cy_r[32:0];
            ph_r    <= 4'd9;
            state_r <= S_MGO;
          end else begin
            if (!cz_r[32]) begin
              cx_r <= cx_r - cdx;
              cy_r <= cy_r + cdy;
              cz_r <= cz_r - cat;
            end else begin
              cx_r <= cx_r + cdx;
              cy_r <= cy_r - cdy;
              cz_r <= cz_r + cat;
            end
            ci_r <= ci_r + 5'd1;
          end
        end
        S_DIV: begin
          if (dcnt_r == 7'd64) begin
            if (ph_r == 4'd11) begin
              x_r     <= x_r + dquo[31:0];
              state_r <= S_MGO;
            end else begin
              y_r     <= y_r + dquo[31:0];
              yaw_r   <= yaw_r + yinc_r;
              state_r <= S_EMIT;
            end
          end else begin
            drem_r <= dbit ? 20'(dtrial - US_PER_S) : dtrial[19:0];
            dmag_r <= {dmag_r[62:0], dbit};
            dcnt_r <= dcnt_r + 7'd1;
          end
        end
        S_EMIT: begin
          if (emit_go) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // rpm selection and step length latched on transfer
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rpm_r_r <= swap_r ? in_rpm_motor1 : in_rpm_motor0;
      rpm_l_r <= swap_r ? in_rpm_motor0 : in_rpm_motor1;
      dt_r    <= dt_full[DT_W-1:0];
    end
    if (emit_go) begin
      ox_r   <= x_r;
      oy_r   <= y_r;
      oyaw_r <= yaw_r;
      olin_r <= speed_lin_r;
      oang_r <= speed_ang_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pos_x     = ox_r;
  assign out_pos_y     = oy_r;
  assign out_heading   = oyaw_r;
  assign out_lin_speed = olin_r;
  assign out_turn_rate = oang_r;

endmodule
